### sv/led_command_frame_parser_unit_macros.svh
// Assertion helpers shared by the parser modules.
`ifndef LED_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH
`define LED_COMMAND_FRAME_PARSER_UNIT_MACROS_SVH

// When the antecedent holds, the consequent holds in the same cycle.
`define LFP_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define LFP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### sv/lfp_pkg.sv
`timescale 1ns / 1ps

package lfp_pkg;

   localparam int DESCRIPTOR_BYTES_DEFAULT = 4;
   localparam int DESC_IDX_W = 2;
   localparam int CSR_INDEX_W = 8;

   localparam logic [7:0] COLUMN_COUNT_RESET = 8'd80;
   localparam logic [7:0] LINE_COUNT_RESET = 8'd24;

   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_COUNT = 8'd1;

   localparam logic [7:0] CMD_HELLO = 8'd1;
   localparam logic [7:0] CMD_LED = 8'd2;
   localparam logic [7:0] CMD_MOVE = 8'd3;
   localparam logic [7:0] CMD_CONFIG = 8'd4;
   localparam logic [7:0] CMD_CRC = 8'd5;

   localparam logic [31:0] HELO_WORD = 32'h4F4C4548;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [1:0] KIND_LED = 2'd0;
   localparam logic [1:0] KIND_CRC = 2'd1;
   localparam logic [1:0] KIND_ACK = 2'd2;
   localparam logic [1:0] KIND_FAULT = 2'd3;

   localparam logic [2:0] FAULT_NONE = 3'd0;
   localparam logic [2:0] FAULT_UNKNOWN_ID = 3'd1;
   localparam logic [2:0] FAULT_BAD_HELLO = 3'd2;
   localparam logic [2:0] FAULT_NO_HELLO = 3'd3;
   localparam logic [2:0] FAULT_BAD_LENGTH = 3'd4;
   localparam logic [2:0] FAULT_RANGE = 3'd5;
   localparam logic [2:0] FAULT_BAD_FLAG = 3'd6;

   typedef enum logic [3:0] {
      ST_WAIT,
      ST_PROC,
      ST_START,
      ST_LED_CHECK,
      ST_CRC,
      ST_EMIT_A,
      ST_EMIT_B,
      ST_HALT
   } lfp_state_type;

   typedef enum logic [1:0] {
      PH_ID,
      PH_LEN,
      PH_PAYLOAD
   } lfp_phase_type;

   typedef enum logic [1:0] {
      FIRST_NONE,
      FIRST_LED,
      FIRST_CRC
   } lfp_first_type;

   typedef enum logic [1:0] {
      SECOND_NONE,
      SECOND_ACK,
      SECOND_FAULT
   } lfp_second_type;

   typedef struct packed {
      logic       capture;
      logic       set_id;
      logic       len_byte;
      logic       frame_start;
      logic       crc_init;
      logic       mod_start;
      logic       pay_led;
      logic       pay_asm;
      logic       crc_xor;
      logic       crc_step;
      logic       set_hello;
      logic       set_cursor;
      logic       set_debug;
      logic       emit;
      logic [1:0] emit_kind;
      logic [2:0] emit_fault;
      logic       emit_last;
   } lfp_cmd_type;

   typedef struct packed {
      logic is_hello;
      logic is_led;
      logic is_move;
      logic is_cfg;
      logic is_crc;
      logic len_last;
      logic len_ok;
      logic len_zero;
      logic mod_zero;
      logic cursor_ok;
      logic range_ok;
      logic hello_seen;
      logic desc_last;
      logic pay_last;
      logic helo_ok;
      logic move_ok;
      logic flag_ok;
      logic crc_last;
      logic out_free;
   } lfp_status_type;

endpackage

### sv/lfp_ctrl.sv
`timescale 1ns / 1ps

`include "led_command_frame_parser_unit_macros.svh"

module lfp_ctrl
   import lfp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  lfp_status_type status,
   output lfp_cmd_type    cmd
);

   lfp_state_type  state_ff, state_in;
   lfp_phase_type  phase_ff, phase_in;
   lfp_first_type  first_ff, first_in;
   lfp_second_type second_ff, second_in;
   logic [2:0]     fault_ff, fault_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_WAIT;
         phase_ff  <= PH_ID;
         first_ff  <= FIRST_NONE;
         second_ff <= SECOND_NONE;
         fault_ff  <= FAULT_NONE;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         fault_ff  <= fault_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      first_in  = first_ff;
      second_in = second_ff;
      fault_in  = fault_ff;
      req_stall = 1'b1;
      cmd       = '0;

      unique case (state_ff)
         ST_WAIT: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               first_in    = FIRST_NONE;
               second_in   = SECOND_NONE;
               fault_in    = FAULT_NONE;
               state_in    = ST_PROC;
            end
         end
         ST_PROC: begin
            state_in = ST_WAIT;
            unique case (phase_ff)
               PH_ID: begin
                  cmd.set_id = 1'b1;
                  phase_in   = PH_LEN;
               end
               PH_LEN: begin
                  cmd.len_byte = 1'b1;
                  if (status.len_last) begin
                     state_in = ST_START;
                  end
               end
               default: begin
                  if (status.is_led) begin
                     cmd.pay_led = 1'b1;
                     first_in    = status.desc_last ? FIRST_LED : FIRST_NONE;
                     if (status.pay_last) begin
                        second_in = SECOND_ACK;
                        phase_in  = PH_ID;
                     end
                     state_in = ST_EMIT_A;
                  end else if (status.is_crc) begin
                     cmd.crc_xor = 1'b1;
                     if (status.pay_last) begin
                        first_in  = FIRST_CRC;
                        second_in = SECOND_ACK;
                        phase_in  = PH_ID;
                     end
                     state_in = ST_CRC;
                  end else if (status.is_hello || status.is_move || status.is_cfg) begin
                     cmd.pay_asm = 1'b1;
                     if (status.pay_last) begin
                        phase_in  = PH_ID;
                        second_in = SECOND_ACK;
                        state_in  = ST_EMIT_B;
                        if (status.is_hello) begin
                           if (!status.helo_ok) begin
                              second_in = SECOND_FAULT;
                              fault_in  = FAULT_BAD_HELLO;
                           end else begin
                              cmd.set_hello = 1'b1;
                           end
                        end else if (!status.hello_seen) begin
                           second_in = SECOND_FAULT;
                           fault_in  = FAULT_NO_HELLO;
                        end else if (status.is_move) begin
                           if (!status.move_ok) begin
                              second_in = SECOND_FAULT;
                              fault_in  = FAULT_RANGE;
                           end else begin
                              cmd.set_cursor = 1'b1;
                           end
                        end else begin
                           if (!status.flag_ok) begin
                              second_in = SECOND_FAULT;
                              fault_in  = FAULT_BAD_FLAG;
                           end else begin
                              cmd.set_debug = 1'b1;
                           end
                        end
                     end
                  end else begin
                     phase_in = PH_ID;
                  end
               end
            endcase
         end
         ST_START: begin
            cmd.frame_start = 1'b1;
            phase_in        = PH_PAYLOAD;
            state_in        = ST_WAIT;
            if (status.is_led) begin
               cmd.mod_start = 1'b1;
               state_in      = ST_LED_CHECK;
            end else if (status.is_crc) begin
               cmd.crc_init = 1'b1;
               if (status.len_zero) begin
                  first_in  = FIRST_CRC;
                  second_in = SECOND_ACK;
                  phase_in  = PH_ID;
                  state_in  = ST_EMIT_A;
               end
            end else if (status.is_hello || status.is_move || status.is_cfg) begin
               if (!status.len_ok) begin
                  second_in = SECOND_FAULT;
                  fault_in  = FAULT_BAD_LENGTH;
                  phase_in  = PH_ID;
                  state_in  = ST_EMIT_B;
               end
            end else begin
               second_in = SECOND_FAULT;
               fault_in  = FAULT_UNKNOWN_ID;
               phase_in  = PH_ID;
               state_in  = ST_EMIT_B;
            end
         end
         ST_LED_CHECK: begin
            state_in = ST_EMIT_B;
            phase_in = PH_ID;
            if (!status.mod_zero) begin
               second_in = SECOND_FAULT;
               fault_in  = FAULT_BAD_LENGTH;
            end else if (!status.cursor_ok) begin
               second_in = SECOND_FAULT;
               fault_in  = FAULT_RANGE;
            end else if (!status.hello_seen) begin
               second_in = SECOND_FAULT;
               fault_in  = FAULT_NO_HELLO;
            end else if (status.len_zero) begin
               second_in = SECOND_ACK;
            end else if (!status.range_ok) begin
               second_in = SECOND_FAULT;
               fault_in  = FAULT_RANGE;
            end else begin
               phase_in = PH_PAYLOAD;
               state_in = ST_WAIT;
            end
         end
         ST_CRC: begin
            cmd.crc_step = 1'b1;
            if (status.crc_last) begin
               state_in = ST_EMIT_A;
            end
         end
         ST_EMIT_A: begin
            if (first_ff == FIRST_NONE) begin
               state_in = ST_EMIT_B;
            end else if (status.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = (first_ff == FIRST_LED) ? KIND_LED : KIND_CRC;
               cmd.emit_last = (second_ff == SECOND_NONE);
               state_in      = ST_EMIT_B;
            end
         end
         ST_EMIT_B: begin
            if (second_ff == SECOND_NONE) begin
               state_in = ST_WAIT;
            end else if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.emit_last  = 1'b1;
               if (second_ff == SECOND_FAULT) begin
                  cmd.emit_kind  = KIND_FAULT;
                  cmd.emit_fault = fault_ff;
                  state_in       = ST_HALT;
               end else begin
                  cmd.emit_kind = KIND_ACK;
                  state_in      = ST_WAIT;
               end
            end
         end
         ST_HALT: begin
            // Bytes are still taken so the sender never hangs, but they are dropped.
            req_stall = 1'b0;
         end
         default: begin
            state_in = ST_WAIT;
         end
      endcase
   end

   `LFP_ASSERT_SAME(a_halt_silent, clock, reset, state_ff == ST_HALT, !cmd.emit, "emit after fault")
   `LFP_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit, status.out_free, "emit into busy output")
   `LFP_ASSERT_NEXT(a_fault_halts, clock, reset,
      cmd.emit && cmd.emit_kind == KIND_FAULT, state_ff == ST_HALT, "fault did not halt")

endmodule

### sv/lfp_dp.sv
`timescale 1ns / 1ps

`include "led_command_frame_parser_unit_macros.svh"

module lfp_dp
   import lfp_pkg::*;
#(
   parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     req_rx_byte,
   input  logic [7:0]     column_count,
   input  logic [7:0]     line_count,
   input  lfp_cmd_type    cmd,
   output lfp_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic [1:0]     rsp_kind,
   output logic [7:0]     rsp_led_column,
   output logic [7:0]     rsp_led_line,
   output logic [31:0]    rsp_led_descriptor,
   output logic [31:0]    rsp_crc_value,
   output logic           rsp_debug_enabled,
   output logic [2:0]     rsp_fault_code,
   output logic           rsp_last
);

   localparam logic [2:0] DESC_W3 = 3'(DESCRIPTOR_BYTES);
   localparam logic [DESC_IDX_W-1:0] DESC_LAST = DESC_IDX_W'(DESCRIPTOR_BYTES - 1);
   localparam logic [1:0] DESC_MASK = 2'(DESCRIPTOR_BYTES - 1);

   logic [7:0]  rx_ff;
   logic [7:0]  id_ff;
   logic [31:0] len_ff, cnt_ff;
   logic [63:0] asm_ff;
   logic [7:0]  col_ff, line_ff;
   logic        hello_ff, dbg_ff;
   logic [31:0] crc_ff;
   logic [2:0]  bit_ff;
   logic [DESC_IDX_W-1:0] k_ff;
   logic [31:0] desc_ff;
   logic [1:0]  rem_ff;
   logic [15:0] prod_ff, limit_ff;
   logic        rpos_ff;
   logic [19:0] rd_ff;
   logic [7:0]  st_col_ff, st_line_ff;
   logic [31:0] st_desc_ff;

   logic        out_valid_ff;
   logic [1:0]  out_kind_ff;
   logic [7:0]  out_col_ff, out_line_ff;
   logic [31:0] out_desc_ff, out_crc_ff;
   logic        out_dbg_ff, out_last_ff;
   logic [2:0]  out_fault_ff;

   logic [63:0] asm_in;
   logic [31:0] desc_in;
   logic [9:0]  len_sum;
   logic [3:0]  len_fold1;
   logic [2:0]  len_fold2;
   logic [1:0]  len_mod3;
   logic [1:0]  len_rem;
   logic [17:0] r_val;
   logic        desc_last;
   logic        out_free;

   assign asm_in    = asm_ff | (64'(rx_ff) << {cnt_ff[2:0], 3'b000});
   assign desc_in   = ((k_ff == '0) ? 32'd0 : desc_ff) | (32'(rx_ff) << {k_ff, 3'b000});
   assign r_val     = {2'b00, limit_ff} - {2'b00, prod_ff} - {10'd0, col_ff};
   assign desc_last = (k_ff == DESC_LAST);
   assign out_free  = !out_valid_ff || !rsp_stall;

   // Length remainder: a mask for sizes of one, two and four bytes; for three bytes
   // the digits base 256 and then base 4 are summed, since both bases are 1 modulo 3.
   assign len_sum   = {2'b00, len_ff[7:0]} + {2'b00, len_ff[15:8]}
                    + {2'b00, len_ff[23:16]} + {2'b00, len_ff[31:24]};
   assign len_fold1 = {2'b00, len_sum[1:0]} + {2'b00, len_sum[3:2]} + {2'b00, len_sum[5:4]}
                    + {2'b00, len_sum[7:6]} + {2'b00, len_sum[9:8]};
   assign len_fold2 = {1'b0, len_fold1[1:0]} + {1'b0, len_fold1[3:2]};
   assign len_mod3  = (len_fold2 >= 3'd6) ? 2'(len_fold2 - 3'd6)
                    : (len_fold2 >= 3'd3) ? 2'(len_fold2 - 3'd3) : len_fold2[1:0];
   assign len_rem   = (DESCRIPTOR_BYTES == 3) ? len_mod3 : (len_ff[1:0] & DESC_MASK);

   always_comb begin
      status            = '0;
      status.is_hello   = (id_ff == CMD_HELLO);
      status.is_led     = (id_ff == CMD_LED);
      status.is_move    = (id_ff == CMD_MOVE);
      status.is_cfg     = (id_ff == CMD_CONFIG);
      status.is_crc     = (id_ff == CMD_CRC);
      status.len_last   = (cnt_ff[1:0] == 2'd3);
      status.len_ok     = (status.is_hello && len_ff == 32'd4)
                       || (status.is_move && len_ff == 32'd8)
                       || (status.is_cfg && len_ff == 32'd1);
      status.len_zero   = (len_ff == 32'd0);
      status.mod_zero   = (rem_ff == 2'd0);
      status.cursor_ok  = (col_ff < column_count) && (line_ff < line_count);
      status.range_ok   = rpos_ff && (len_ff <= {12'd0, rd_ff});
      status.hello_seen = hello_ff;
      status.desc_last  = desc_last;
      status.pay_last   = (cnt_ff + 32'd1 == len_ff);
      status.helo_ok    = (asm_in[31:0] == HELO_WORD);
      status.move_ok    = (asm_in[31:0] < {24'd0, column_count})
                       && (asm_in[63:32] < {24'd0, line_count});
      status.flag_ok    = (asm_in[7:0] < 8'd2);
      status.crc_last   = (bit_ff == 3'd7);
      status.out_free   = out_free;
   end

   // Range terms settle while the header bytes arrive.
   always_ff @(posedge clock) begin
      prod_ff  <= line_ff * column_count;
      limit_ff <= line_count * column_count;
      rpos_ff  <= !r_val[17] && (r_val != 18'd0);
      rd_ff    <= 20'(r_val[16:0]) * 20'(DESC_W3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff    <= '0;
         len_ff   <= '0;
         cnt_ff   <= '0;
         asm_ff   <= '0;
         col_ff   <= '0;
         line_ff  <= '0;
         hello_ff <= 1'b0;
         dbg_ff   <= 1'b0;
         crc_ff   <= CRC_INIT;
         bit_ff   <= '0;
         k_ff     <= '0;
         rem_ff   <= '0;
      end else begin
         if (cmd.set_id) begin
            id_ff  <= rx_ff;
            len_ff <= '0;
            cnt_ff <= '0;
         end
         if (cmd.len_byte) begin
            len_ff <= len_ff | (32'(rx_ff) << {cnt_ff[1:0], 3'b000});
            cnt_ff <= cnt_ff + 32'd1;
         end
         if (cmd.frame_start) begin
            cnt_ff <= '0;
            asm_ff <= '0;
            k_ff   <= '0;
         end
         if (cmd.crc_init) begin
            crc_ff <= CRC_INIT;
         end
         if (cmd.mod_start) begin
            rem_ff <= len_rem;
         end
         if (cmd.pay_led) begin
            cnt_ff <= cnt_ff + 32'd1;
            k_ff   <= desc_last ? '0 : k_ff + 1'b1;
            if (desc_last) begin
               if ({1'b0, col_ff} + 9'd1 >= {1'b0, column_count}) begin
                  col_ff  <= '0;
                  line_ff <= line_ff + 8'd1;
               end else begin
                  col_ff <= col_ff + 8'd1;
               end
            end
         end
         if (cmd.pay_asm) begin
            asm_ff <= asm_in;
            cnt_ff <= cnt_ff + 32'd1;
         end
         if (cmd.crc_xor) begin
            crc_ff <= crc_ff ^ {24'd0, rx_ff};
            bit_ff <= '0;
            cnt_ff <= cnt_ff + 32'd1;
         end
         if (cmd.crc_step) begin
            crc_ff <= (crc_ff >> 1) ^ (crc_ff[0] ? CRC_POLY : 32'd0);
            bit_ff <= bit_ff + 3'd1;
         end
         if (cmd.set_hello) begin
            hello_ff <= 1'b1;
         end
         if (cmd.set_cursor) begin
            col_ff  <= asm_in[7:0];
            line_ff <= asm_in[39:32];
         end
         if (cmd.set_debug) begin
            dbg_ff <= asm_in[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rx_ff <= req_rx_byte;
      end
      if (cmd.pay_led) begin
         desc_ff <= desc_in;
         if (desc_last) begin
            st_desc_ff <= desc_in;
            st_col_ff  <= col_ff;
            st_line_ff <= line_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_kind_ff  <= cmd.emit_kind;
         out_fault_ff <= cmd.emit_fault;
         out_last_ff  <= cmd.emit_last;
         out_dbg_ff   <= dbg_ff;
         out_col_ff   <= (cmd.emit_kind == KIND_LED) ? st_col_ff : 8'd0;
         out_line_ff  <= (cmd.emit_kind == KIND_LED) ? st_line_ff : 8'd0;
         out_desc_ff  <= (cmd.emit_kind == KIND_LED) ? st_desc_ff : 32'd0;
         out_crc_ff   <= (cmd.emit_kind == KIND_CRC) ? ~crc_ff : 32'd0;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_kind           = out_kind_ff;
   assign rsp_led_column     = out_col_ff;
   assign rsp_led_line       = out_line_ff;
   assign rsp_led_descriptor = out_desc_ff;
   assign rsp_crc_value      = out_crc_ff;
   assign rsp_debug_enabled  = out_dbg_ff;
   assign rsp_fault_code     = out_fault_ff;
   assign rsp_last           = out_last_ff;

   `LFP_ASSERT_SAME(a_desc_idx, clock, reset, 1'b1, k_ff <= DESC_LAST, "descriptor index overrun")
   `LFP_ASSERT_SAME(a_rem_range, clock, reset, 1'b1, {1'b0, rem_ff} < DESC_W3, "remainder too big")
   `LFP_ASSERT_NEXT(a_load_valid, clock, reset, cmd.emit, out_valid_ff, "result not shown")

endmodule

### sv/led_command_frame_parser_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_rx_byte
// rsp_      out        rsp_valid / rsp_stall  kind, led, crc, debug, fault, last
// csr_      in         csr_valid / csr_ready  csr_index, csr_data
//
// Most requests take the byte in the wait state and process it in the process state. The last
// length byte then passes the start state, the LED check state in an LED frame, and an emit
// state per result. An LED payload byte passes both emit states. A CRC payload byte is folded
// in one bit per cycle in the CRC state; a byte ending a hello, move or configure frame
// passes emit state B. Reset is synchronous: columns 80, lines 24, cursor home, no hello seen.
// A stalled result holds the controller in its emit state.

module led_command_frame_parser_unit
   import lfp_pkg::*;
#(
   parameter int DESCRIPTOR_BYTES = DESCRIPTOR_BYTES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_kind,
   output logic [7:0]             rsp_led_column,
   output logic [7:0]             rsp_led_line,
   output logic [31:0]            rsp_led_descriptor,
   output logic [31:0]            rsp_crc_value,
   output logic                   rsp_debug_enabled,
   output logic [2:0]             rsp_fault_code,
   output logic                   rsp_last,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_data
);

   logic [7:0]     column_count_ff;
   logic [7:0]     line_count_ff;
   lfp_cmd_type    cmd;
   lfp_status_type status;

   // The register port never pushes back; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= COLUMN_COUNT_RESET;
         line_count_ff   <= LINE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_data;
            CSR_LINE_COUNT:   line_count_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // The controller sequences each request; the datapath holds frame state.
   lfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lfp_dp #(
      .DESCRIPTOR_BYTES (DESCRIPTOR_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_rx_byte        (req_rx_byte),
      .column_count       (column_count_ff),
      .line_count         (line_count_ff),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_led_column     (rsp_led_column),
      .rsp_led_line       (rsp_led_line),
      .rsp_led_descriptor (rsp_led_descriptor),
      .rsp_crc_value      (rsp_crc_value),
      .rsp_debug_enabled  (rsp_debug_enabled),
      .rsp_fault_code     (rsp_fault_code),
      .rsp_last           (rsp_last)
   );

endmodule
